### src/betrm_pkg.sv
// betrm_pkg: shared types, constants and helpers of the two-region memory
// used by the interfaces, the region banks and the top level; no dependencies
`timescale 1ns / 1ps

package betrm_pkg;

    localparam int unsigned DATA_DEPTH_DEF  = 65536;
    localparam int unsigned STACK_DEPTH_DEF = 65536;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned SIZE_W    = 17;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_END  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_SIZE = 2'd3;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_OFFS,
        S_ACCESS,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic        en;
        logic        we;
        logic [1:0]  size_code;
        logic [63:0] off;
        logic [63:0] wdata;
    } t_mem_cmd;

    // true when n bytes from offset off lie inside a region of size bytes
    function automatic logic fits(input logic [63:0] off, input logic [63:0] n,
                                  input logic [63:0] size);
        logic [63:0] room;
        room = size - off;
        return (off < size) && (n <= room);
    endfunction

    function automatic logic [63:0] clamp_size(input logic [SIZE_W-1:0] size,
                                               input logic [63:0] depth);
        logic [63:0] wide;
        wide = 64'(size);
        return (wide > depth) ? depth : wide;
    endfunction

endpackage

### src/betrm_if.sv
// betrm_if: valid/ready channels for requests, responses and register writes
// depends on betrm_pkg for the register index width
`timescale 1ns / 1ps

interface betrm_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [1:0]  size_code;
    logic [63:0] address;
    logic [63:0] write_data;

    modport source (output valid, opcode, size_code, address, write_data, input ready);
    modport sink   (input valid, opcode, size_code, address, write_data, output ready);
endinterface

interface betrm_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic        fault;

    modport source (output valid, read_data, fault, input ready);
    modport sink   (input valid, read_data, fault, output ready);
endinterface

interface betrm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [betrm_pkg::CFG_IDX_W-1:0]    index;
    logic [63:0]                        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/betrm_ram.sv
// betrm_ram: generic single-port synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module betrm_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 8,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/betrm_region.sv
// betrm_region: one byte store split over eight byte-wide banks
// steers a big-endian window of 1 to 8 bytes; depends on betrm_pkg, betrm_ram
`timescale 1ns / 1ps

module betrm_region #(
    parameter int unsigned DEPTH = betrm_pkg::DATA_DEPTH_DEF
) (
    input  logic                i_clk,
    input  betrm_pkg::t_mem_cmd i_cmd,
    output logic [63:0]         o_rdata
);

    localparam int unsigned ROWS  = (DEPTH + 7) / 8;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [2:0]       w_lane;
    logic [3:0]       w_n;
    logic [ROW_W-1:0] w_row;
    logic [ROW_W-1:0] w_row_nx;
    logic [7:0]       w_q [8];

    logic [2:0]       r_lane;
    logic [1:0]       r_size;

    assign w_lane   = i_cmd.off[2:0];
    assign w_n      = 4'd1 << i_cmd.size_code;
    assign w_row    = i_cmd.off[ROW_W+2:3];
    assign w_row_nx = w_row + ROW_W'(1);

    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [2:0]       w_pos;
        logic             w_act;
        logic [ROW_W-1:0] w_addr;
        logic [5:0]       w_sh;
        logic [7:0]       w_wd;

        // byte position inside the window that lands on this bank
        assign w_pos  = 3'(b) - w_lane;
        assign w_act  = {1'b0, w_pos} < w_n;
        assign w_addr = (3'(b) < w_lane) ? w_row_nx : w_row;
        assign w_sh   = {3'(w_n - 4'd1 - {1'b0, w_pos}), 3'b000};
        assign w_wd   = 8'(i_cmd.wdata >> w_sh);

        betrm_ram #(
            .WIDTH  (8),
            .DEPTH  (ROWS),
            .ADDR_W (ROW_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_en    (i_cmd.en & w_act),
            .i_we    (i_cmd.we),
            .i_addr  (w_addr),
            .i_wdata (w_wd),
            .o_rdata (w_q[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_lane <= w_lane;
            r_size <= i_cmd.size_code;
        end
    end

    // gather the window, first byte most significant
    always_comb begin
        logic [3:0] rn;
        logic [2:0] bank;
        logic [5:0] sh;
        o_rdata = '0;
        rn      = 4'd1 << r_size;
        bank    = '0;
        sh      = '0;
        for (int j = 0; j < 8; j++) begin
            if (4'(j) < rn) begin
                bank    = r_lane + 3'(j);
                sh      = {3'(rn - 4'd1 - 4'(j)), 3'b000};
                o_rdata = o_rdata | (64'(w_q[bank]) << sh);
            end
        end
    end

endmodule

### src/big_endian_two_region_memory_top.sv
// big_endian_two_region_memory_top: request sequencer, region checks and result register
// depends on betrm_pkg, betrm_if, betrm_region
`timescale 1ns / 1ps

// Byte-addressed big-endian memory with a data region from data_base and a stack
// region that ends just below its configured end address, each held in eight byte
// banks of synchronous ram.
// A request is taken only while the sequencer is idle and its result is loaded into
// the output register after the steps of offset and stack base, stack offset and data
// fit check, stack fit check and bank access, and read gather, so the block takes no
// new request until the last result is loaded; the steps split the chain of 64-bit
// subtracts and compares of the region checks. A result that is not yet taken
// holds the last step until the output register frees. Bytes never written read
// back undefined. Register writes are taken in any cycle and must only be issued
// while no request is in flight.

module big_endian_two_region_memory_top #(
    parameter int unsigned DATA_DEPTH  = betrm_pkg::DATA_DEPTH_DEF,
    parameter int unsigned STACK_DEPTH = betrm_pkg::STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    betrm_cfg_if.sink    i_cfg,
    betrm_req_if.sink    i_req,
    betrm_rsp_if.source  o_rsp
);

    betrm_pkg::t_state r_state, n_state;

    logic [63:0]                  r_data_base;
    logic [betrm_pkg::SIZE_W-1:0] r_data_size;
    logic [63:0]                  r_stack_end;
    logic [betrm_pkg::SIZE_W-1:0] r_stack_size;

    logic        r_op;
    logic [1:0]  r_size;
    logic [63:0] r_addr;
    logic [63:0] r_wdata;
    logic [63:0] r_doff;
    logic [63:0] r_sbase;
    logic [63:0] r_soff;
    logic        r_dfit;
    logic        r_fault;
    logic        r_use_stack;

    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic        r_out_fault;

    logic [63:0] w_dsize;
    logic [63:0] w_ssize;
    logic [63:0] w_n;
    logic        w_sfit;
    logic        w_hit;
    logic        w_req_xfer;
    logic        w_load;
    logic        w_issue;
    logic [63:0] w_dq;
    logic [63:0] w_sq;

    betrm_pkg::t_mem_cmd w_dcmd;
    betrm_pkg::t_mem_cmd w_scmd;

    assign w_dsize    = betrm_pkg::clamp_size(r_data_size, 64'(DATA_DEPTH));
    assign w_ssize    = betrm_pkg::clamp_size(r_stack_size, 64'(STACK_DEPTH));
    assign w_n        = 64'(4'd1 << r_size);
    assign w_sfit     = betrm_pkg::fits(r_soff, w_n, w_ssize);
    assign w_hit      = r_dfit | w_sfit;
    assign w_req_xfer = i_req.valid & i_req.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            betrm_pkg::S_IDLE: begin
                if (w_req_xfer) begin
                    n_state = betrm_pkg::S_BASE;
                end
            end
            betrm_pkg::S_BASE:   n_state = betrm_pkg::S_OFFS;
            betrm_pkg::S_OFFS:   n_state = betrm_pkg::S_ACCESS;
            betrm_pkg::S_ACCESS: n_state = betrm_pkg::S_FINISH;
            betrm_pkg::S_FINISH: begin
                if (w_load) begin
                    n_state = betrm_pkg::S_IDLE;
                end
            end
            default: n_state = betrm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready = 1'b0;
        i_cfg.ready = 1'b1;
        w_issue     = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            betrm_pkg::S_IDLE:   i_req.ready = 1'b1;
            betrm_pkg::S_ACCESS: w_issue = w_hit;
            betrm_pkg::S_FINISH: w_load = ~r_out_valid | o_rsp.ready;
            default: begin
            end
        endcase
    end

    always_comb begin
        w_dcmd.en        = w_issue & r_dfit;
        w_dcmd.we        = r_op == betrm_pkg::OP_WRITE;
        w_dcmd.size_code = r_size;
        w_dcmd.off       = r_doff;
        w_dcmd.wdata     = r_wdata;
        w_scmd.en        = w_issue & ~r_dfit;
        w_scmd.we        = r_op == betrm_pkg::OP_WRITE;
        w_scmd.size_code = r_size;
        w_scmd.off       = r_soff;
        w_scmd.wdata     = r_wdata;
    end

    betrm_region #(
        .DEPTH (DATA_DEPTH)
    ) u_data (
        .i_clk   (i_clk),
        .i_cmd   (w_dcmd),
        .o_rdata (w_dq)
    );

    betrm_region #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_cmd   (w_scmd),
        .o_rdata (w_sq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= betrm_pkg::S_IDLE;
            r_data_base  <= '0;
            r_data_size  <= '0;
            r_stack_end  <= '0;
            r_stack_size <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    betrm_pkg::REG_DATA_BASE:  r_data_base  <= i_cfg.data;
                    betrm_pkg::REG_DATA_SIZE:  r_data_size  <= i_cfg.data[betrm_pkg::SIZE_W-1:0];
                    betrm_pkg::REG_STACK_END:  r_stack_end  <= i_cfg.data;
                    betrm_pkg::REG_STACK_SIZE: r_stack_size <= i_cfg.data[betrm_pkg::SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_xfer) begin
            r_op    <= i_req.opcode;
            r_size  <= i_req.size_code;
            r_addr  <= i_req.address;
            r_wdata <= i_req.write_data;
        end
        if (r_state == betrm_pkg::S_BASE) begin
            r_doff  <= r_addr - r_data_base;
            r_sbase <= r_stack_end - w_ssize;
        end
        if (r_state == betrm_pkg::S_OFFS) begin
            r_soff <= r_addr - r_sbase;
            r_dfit <= betrm_pkg::fits(r_doff, w_n, w_dsize);
        end
        if (r_state == betrm_pkg::S_ACCESS) begin
            r_fault     <= ~w_hit;
            r_use_stack <= ~r_dfit;
        end
        if (w_load) begin
            r_out_fault <= r_fault;
            if (r_fault || r_op == betrm_pkg::OP_WRITE) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= r_use_stack ? w_sq : w_dq;
            end
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_data;
    assign o_rsp.fault     = r_out_fault;

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_xfer |=> r_state == betrm_pkg::S_BASE)
        else $error("request taken outside idle");

    a_no_access_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dcmd.en || w_scmd.en) |-> (r_dfit || w_sfit))
        else $error("bank access for a request outside both regions");

    a_one_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_dcmd.en && w_scmd.en))
        else $error("both regions accessed at once");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.fault) |-> o_rsp.read_data == 64'd0)
        else $error("faulting result carries data");

    a_load_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_rsp.valid && r_state == betrm_pkg::S_IDLE))
        else $error("result load did not present a result");
`endif

endmodule

### bench/big_endian_two_region_memory_top_tb.sv
// testbench of big_endian_two_region_memory_top: directed and random loads and stores
// checked against a byte-level model of both regions; uses betrm_pkg, betrm_if and the rtl
`timescale 1ns / 1ps

module big_endian_two_region_memory_top_tb;

    localparam logic [1:0] SZ_BYTE   = 2'd0;
    localparam logic [1:0] SZ_HALF   = 2'd1;
    localparam logic [1:0] SZ_WORD   = 2'd2;
    localparam logic [1:0] SZ_DOUBLE = 2'd3;

    localparam int unsigned SW = betrm_pkg::SIZE_W;

    typedef enum logic [1:0] {
        HIT_NONE,
        HIT_DATA,
        HIT_STACK
    } t_hit;

    typedef struct packed {
        logic [63:0] rdata;
        logic        fault;
    } t_mem_result;

    logic i_clk;
    logic i_rst_n;

    betrm_cfg_if cfg_ch ();
    betrm_req_if req_ch ();
    betrm_rsp_if rsp_ch ();

    big_endian_two_region_memory_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic [63:0]   cur_data_base  = '0;
    logic [SW-1:0] cur_data_size  = '0;
    logic [63:0]   cur_stack_end  = '0;
    logic [SW-1:0] cur_stack_size = '0;

    logic [7:0] data_bytes  [betrm_pkg::DATA_DEPTH_DEF];
    bit         data_valid  [betrm_pkg::DATA_DEPTH_DEF];
    logic [7:0] stack_bytes [betrm_pkg::STACK_DEPTH_DEF];
    bit         stack_valid [betrm_pkg::STACK_DEPTH_DEF];

    t_mem_result pending_results[$];
    t_mem_result due;
    int          errors     = 0;
    int          send_burst = 0;
    int          rsp_burst  = 0;
    int          rsp_stall  = 0;
    int          stall_draw = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] region_span(input logic [SW-1:0] size,
                                                input int unsigned depth);
        return (64'(size) > 64'(depth)) ? 64'(depth) : 64'(size);
    endfunction

    // data region first, then stack; off is the byte index in the chosen store
    function automatic t_hit locate(input logic [63:0] addr, input logic [3:0] nb,
                                    output logic [63:0] off);
        logic [63:0] dsz;
        logic [63:0] ssz;
        logic [63:0] doff;
        logic [63:0] soff;
        dsz  = region_span(cur_data_size, betrm_pkg::DATA_DEPTH_DEF);
        ssz  = region_span(cur_stack_size, betrm_pkg::STACK_DEPTH_DEF);
        doff = addr - cur_data_base;
        soff = addr - (cur_stack_end - ssz);
        off  = '0;
        if (doff < dsz && 64'(nb) <= dsz - doff) begin
            off = doff;
            return HIT_DATA;
        end
        if (soff < ssz && 64'(nb) <= ssz - soff) begin
            off = soff;
            return HIT_STACK;
        end
        return HIT_NONE;
    endfunction

    task automatic record_access(input logic op, input logic [1:0] sc,
                                 input logic [63:0] addr, input logic [63:0] wd);
        logic [3:0]  nb;
        logic [63:0] off;
        t_hit        hit;
        t_mem_result res;
        int          idx;
        logic [7:0]  b;
        nb  = 4'd1 << sc;
        hit = locate(addr, nb, off);
        res = '0;
        res.fault = (hit == HIT_NONE);
        if (hit != HIT_NONE) begin
            for (int i = 0; i < int'(nb); i++) begin
                idx = int'(off[16:0]) + i;
                if (op == betrm_pkg::OP_WRITE) begin
                    b = wd[(int'(nb) - 1 - i) * 8 +: 8];
                    if (hit == HIT_DATA) begin
                        data_bytes[idx] = b;
                        data_valid[idx] = 1'b1;
                    end else begin
                        stack_bytes[idx] = b;
                        stack_valid[idx] = 1'b1;
                    end
                end else begin
                    b = (hit == HIT_DATA) ? data_bytes[idx] : stack_bytes[idx];
                    res.rdata = {res.rdata[55:0], b};
                end
            end
        end
        pending_results.push_back(res);
    endtask

    task automatic mem_access(input logic op, input logic [1:0] sc,
                              input logic [63:0] addr, input logic [63:0] wd);
        logic [3:0]  nb;
        logic [63:0] off;
        t_hit        hit;
        logic        op_eff;
        int          gap;
        int          idx;
        nb     = 4'd1 << sc;
        hit    = locate(addr, nb, off);
        op_eff = op;
        // a load touching a byte never stored becomes a store
        if (op == betrm_pkg::OP_READ && hit != HIT_NONE) begin
            for (int i = 0; i < int'(nb); i++) begin
                idx = int'(off[16:0]) + i;
                if ((hit == HIT_DATA && !data_valid[idx]) ||
                    (hit == HIT_STACK && !stack_valid[idx]))
                    op_eff = betrm_pkg::OP_WRITE;
            end
        end
        if (send_burst > 0) begin
            send_burst--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 15) == 0)
                send_burst = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op_eff;
        req_ch.size_code  <= sc;
        req_ch.address    <= addr;
        req_ch.write_data <= wd;
        do @(posedge i_clk); while (!req_ch.ready);
        record_access(op_eff, sc, addr, wd);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_regions(input logic [63:0] dbase, input logic [SW-1:0] dsize,
                               input logic [63:0] stop, input logic [SW-1:0] ssize);
        logic [betrm_pkg::CFG_IDX_W-1:0] idx_list [4];
        logic [63:0]                     val_list [4];
        drain();
        idx_list = '{betrm_pkg::REG_DATA_BASE, betrm_pkg::REG_DATA_SIZE,
                     betrm_pkg::REG_STACK_END, betrm_pkg::REG_STACK_SIZE};
        val_list = '{dbase, 64'(dsize), stop, 64'(ssize)};
        cfg_ch.valid <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            cfg_ch.index <= idx_list[i];
            cfg_ch.data  <= val_list[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            case (idx_list[i])
                betrm_pkg::REG_DATA_BASE:  cur_data_base  = val_list[i];
                betrm_pkg::REG_DATA_SIZE:  cur_data_size  = val_list[i][SW-1:0];
                betrm_pkg::REG_STACK_END:  cur_stack_end  = val_list[i];
                betrm_pkg::REG_STACK_SIZE: cur_stack_size = val_list[i][SW-1:0];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly near the ends of a region, some anywhere inside, some wild addresses
    task automatic random_access();
        int          pick;
        int          mode;
        longint      step;
        logic [63:0] base;
        logic [63:0] span;
        logic [63:0] addr;
        pick = $urandom_range(0, 99);
        mode = $urandom_range(0, 2);
        if (pick < 45) begin
            base = cur_data_base;
            span = region_span(cur_data_size, betrm_pkg::DATA_DEPTH_DEF);
        end else begin
            span = region_span(cur_stack_size, betrm_pkg::STACK_DEPTH_DEF);
            base = cur_stack_end - span;
        end
        case (mode)
            0:       step = longint'($urandom_range(0, 79)) - 8;
            1:       step = longint'(span) - 72 + longint'($urandom_range(0, 79));
            default: step = longint'($urandom_range(0, 32'(span)));
        endcase
        addr = (pick < 90) ? base + 64'(step) : {$urandom, $urandom};
        mem_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), addr,
                   {$urandom, $urandom});
    endtask

    task automatic run_random(input int count);
        repeat (count) random_access();
    endtask

    task automatic test_reset_defaults();
        mem_access(betrm_pkg::OP_READ, SZ_DOUBLE, 64'd0, 64'd0);
        mem_access(betrm_pkg::OP_WRITE, SZ_BYTE, '1, '1);
    endtask

    task automatic test_byte_order();
        set_regions(64'h1000, 17'd64, 64'h2000, 17'd64);
        mem_access(betrm_pkg::OP_WRITE, SZ_DOUBLE, 64'h1000, 64'h0123_4567_89AB_CDEF);
        mem_access(betrm_pkg::OP_READ, SZ_DOUBLE, 64'h1000, '0);
        mem_access(betrm_pkg::OP_READ, SZ_BYTE, 64'h1000, '0);
        mem_access(betrm_pkg::OP_READ, SZ_HALF, 64'h1001, '0);
        mem_access(betrm_pkg::OP_READ, SZ_WORD, 64'h1003, '0);
    endtask

    task automatic test_region_bounds();
        mem_access(betrm_pkg::OP_WRITE, SZ_HALF, 64'h103E, '1);
        mem_access(betrm_pkg::OP_READ, SZ_HALF, 64'h103E, '0);
        mem_access(betrm_pkg::OP_WRITE, SZ_WORD, 64'h103E, '1);
        mem_access(betrm_pkg::OP_READ, SZ_DOUBLE, 64'h0FFF, '0);
        mem_access(betrm_pkg::OP_WRITE, SZ_BYTE, 64'h1FC0, '0);
        mem_access(betrm_pkg::OP_READ, SZ_BYTE, 64'h1FC0, '0);
        mem_access(betrm_pkg::OP_WRITE, SZ_DOUBLE, 64'h1FF8, 64'hFEDC_BA98_7654_3210);
        mem_access(betrm_pkg::OP_READ, SZ_DOUBLE, 64'h1FF8, '0);
        mem_access(betrm_pkg::OP_READ, SZ_DOUBLE, 64'h1FF9, '0);
        mem_access(betrm_pkg::OP_WRITE, SZ_BYTE, 64'h2000, '1);
        mem_access(betrm_pkg::OP_READ, SZ_BYTE, '1, '0);
    endtask

    task automatic test_random_regions();
        set_regions({$urandom, $urandom}, 17'(8 * $urandom_range(1, 512)),
                    {$urandom, $urandom}, 17'(8 * $urandom_range(1, 512)));
        run_random(250);
    endtask

    task automatic test_full_regions();
        set_regions({$urandom, $urandom}, 17'h10000, {$urandom, $urandom}, 17'h10000);
        run_random(250);
    endtask

    task automatic test_address_wrap();
        // data region straddles zero, stack region ends at the top of the address space
        set_regions(64'hFFFF_FFFF_FFFF_FFFC, 17'd8, 64'd0, 17'd16);
        mem_access(betrm_pkg::OP_WRITE, SZ_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFC,
                   64'hA5A5_5A5A_0F0F_F0F0);
        mem_access(betrm_pkg::OP_READ, SZ_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFC, '0);
        mem_access(betrm_pkg::OP_WRITE, SZ_DOUBLE, 64'hFFFF_FFFF_FFFF_FFF0,
                   64'h8000_0000_0000_0001);
        mem_access(betrm_pkg::OP_READ, SZ_WORD, 64'hFFFF_FFFF_FFFF_FFF2, '0);
        mem_access(betrm_pkg::OP_READ, SZ_HALF, 64'h2, '0);
        mem_access(betrm_pkg::OP_WRITE, SZ_BYTE, 64'h4, '1);
        set_regions(64'd0 - 64'($urandom_range(1, 200)), 17'd1024,
                    64'($urandom_range(0, 200)), 17'd1024);
        run_random(200);
    endtask

    task automatic test_overlapping_regions();
        logic [63:0] dbase;
        dbase = {$urandom, $urandom};
        set_regions(dbase, 17'($urandom_range(1, 200)),
                    dbase + 64'($urandom_range(0, 300)), 17'($urandom_range(1, 300)));
        run_random(200);
    endtask

    task automatic test_empty_regions();
        set_regions({$urandom, $urandom}, 17'd0, {$urandom, $urandom}, 17'd512);
        run_random(100);
        set_regions({$urandom, $urandom}, 17'd512, {$urandom, $urandom}, 17'd0);
        run_random(100);
    endtask

    task automatic test_extreme_bases();
        set_regions(64'd0, 17'h10000, 64'd0, 17'h10000);
        run_random(125);
        set_regions('1, 17'h10000, '1, 17'd8);
        run_random(125);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= 0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, actual read_data %h fault %b",
                         $time, rsp_ch.read_data, rsp_ch.fault);
            end else begin
                due = pending_results.pop_front();
                if (rsp_ch.read_data !== due.rdata) begin
                    errors++;
                    $display("%0t: read_data mismatch, expected %h, actual %h",
                             $time, due.rdata, rsp_ch.read_data);
                end
                if (rsp_ch.fault !== due.fault) begin
                    errors++;
                    $display("%0t: fault mismatch, expected %b, actual %b",
                             $time, due.fault, rsp_ch.fault);
                end
            end
            if (rsp_burst > 0) begin
                rsp_burst--;
                stall_draw = 0;
            end else begin
                stall_draw = $urandom_range(0, 11);
                if ($urandom_range(0, 15) == 0)
                    rsp_burst = $urandom_range(10, 40);
            end
            rsp_stall    <= stall_draw;
            rsp_ch.ready <= (stall_draw == 0);
        end else if (rsp_stall > 0) begin
            rsp_stall    <= rsp_stall - 1;
            rsp_ch.ready <= (rsp_stall == 1);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= betrm_pkg::REG_DATA_BASE;
        cfg_ch.data       <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= betrm_pkg::OP_READ;
        req_ch.size_code  <= SZ_BYTE;
        req_ch.address    <= '0;
        req_ch.write_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_byte_order();
        test_region_bounds();
        test_random_regions();
        test_full_regions();
        test_address_wrap();
        test_overlapping_regions();
        test_empty_regions();
        test_extreme_bases();
        drain();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20ms;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
